// ===== src/drot_pkg.sv =====
// Shared types, constants and the overlap test of the DMA range ownership table.
package drot_pkg;

    localparam int CHANNEL_COUNT_DEF = 8;
    localparam int MAX_RANGES_DEF    = 5;

    localparam int CH_FIELD_W = 4;
    localparam int ADDR_W     = 32;
    localparam int SIZE_W     = 24;
    localparam int OUT_W      = 3;
    localparam int ENTRY_W    = ADDR_W + SIZE_W;

    typedef enum logic [OUT_W-1:0] {
        CODE_OK         = 3'd0,
        CODE_INVALID    = 3'd1,
        CODE_CONFLICT   = 3'd2,
        CODE_FAULTED    = 3'd3,
        CODE_QUARANTINE = 3'd4
    } t_code;

    typedef enum logic [1:0] {
        VERDICT_CLEAR    = 2'd0,
        VERDICT_CONFLICT = 2'd1,
        VERDICT_OVERFLOW = 2'd2
    } t_verdict;

    localparam logic ACTION_RESERVE = 1'b0;

    // control from the sequencer to the scan engine
    typedef struct packed {
        logic start;
        logic wr_en;
    } t_scan_req;

    // status back from the scan engine
    typedef struct packed {
        logic done;
        logic hit;
    } t_scan_stat;

    // two ranges meet when the later start lies inside the earlier range
    function automatic logic ranges_meet(
        input logic [ADDR_W-1:0] a,
        input logic [SIZE_W-1:0] alen,
        input logic [ADDR_W-1:0] b,
        input logic [SIZE_W-1:0] blen
    );
        logic meet;
        if (a < b) begin
            meet = (b - a) < ADDR_W'(alen);
        end else begin
            meet = (a - b) < ADDR_W'(blen);
        end
        return meet;
    endfunction

endpackage

// ===== src/drot_scan.sv =====
// Owned-range table memory and the sequential overlap scan over it.
module drot_scan #(
    parameter int CHANNEL_COUNT = drot_pkg::CHANNEL_COUNT_DEF,
    parameter int MAX_RANGES    = drot_pkg::MAX_RANGES_DEF,
    localparam int DEPTH  = CHANNEL_COUNT * MAX_RANGES,
    localparam int TBL_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CH_W   = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1,
    localparam int K_W    = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1,
    localparam int CNT_W  = $clog2(MAX_RANGES + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  drot_pkg::t_scan_req           i_req,
    input  logic [drot_pkg::ADDR_W-1:0]   i_addr,
    input  logic [drot_pkg::SIZE_W-1:0]   i_size,
    input  logic [CNT_W-1:0]              i_owner_total,
    input  logic [TBL_W-1:0]              i_wr_addr,
    input  logic [drot_pkg::ENTRY_W-1:0]  i_wr_data,
    output logic [CH_W-1:0]               o_scan_owner,
    output logic [CH_W-1:0]               o_hit_owner,
    output drot_pkg::t_scan_stat          o_stat
);

    logic [drot_pkg::ENTRY_W-1:0] r_mem [DEPTH];
    logic [drot_pkg::ENTRY_W-1:0] r_rd_data;

    logic             r_busy;
    logic             r_issue;
    logic [CH_W-1:0]  r_o;
    logic [K_W-1:0]   r_k;
    logic [TBL_W-1:0] r_a;
    logic             r_tag_vld;
    logic             r_tag_live;
    logic [CH_W-1:0]  r_tag_o;

    logic w_last_issue;
    logic w_hit;
    logic w_done;

    assign w_last_issue = (r_o == CH_W'(CHANNEL_COUNT - 1)) && (r_k == K_W'(MAX_RANGES - 1));
    assign w_hit = r_tag_vld && r_tag_live &&
                   drot_pkg::ranges_meet(i_addr, i_size,
                                         r_rd_data[drot_pkg::ENTRY_W-1:drot_pkg::SIZE_W],
                                         r_rd_data[drot_pkg::SIZE_W-1:0]);
    // entries come in owner order, so the first hit names the lowest owner
    assign w_done = r_busy && (w_hit || (!r_tag_vld && !r_issue));

    assign o_scan_owner = r_o;
    assign o_hit_owner  = r_tag_o;
    assign o_stat.done  = w_done;
    assign o_stat.hit   = w_hit;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[r_a];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_issue   <= 1'b0;
            r_tag_vld <= 1'b0;
            r_o       <= '0;
            r_k       <= '0;
            r_a       <= '0;
        end else if (i_req.start) begin
            r_busy    <= 1'b1;
            r_issue   <= 1'b1;
            r_tag_vld <= 1'b0;
            r_o       <= '0;
            r_k       <= '0;
            r_a       <= '0;
        end else if (w_done) begin
            r_busy    <= 1'b0;
            r_issue   <= 1'b0;
            r_tag_vld <= 1'b0;
        end else if (r_busy && r_issue) begin
            r_tag_vld <= 1'b1;
            r_a       <= r_a + TBL_W'(1);
            if (w_last_issue) begin
                r_issue <= 1'b0;
            end
            if (r_k == K_W'(MAX_RANGES - 1)) begin
                r_k <= '0;
                r_o <= r_o + CH_W'(1);
            end else begin
                r_k <= r_k + K_W'(1);
            end
        end else begin
            r_tag_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag_o    <= r_o;
        r_tag_live <= CNT_W'(r_k) < i_owner_total;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.wr_en |-> !r_busy)
        else $error("table write during scan");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |=> !r_tag_vld || $past(i_req.start) == 1'b0 && !r_busy)
        else $error("read tag without scan");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !r_issue && !w_done) |=> !r_issue)
        else $error("scan reissued after last entry");

endmodule

// ===== src/dma_range_ownership_table_top.sv =====
// Top level of the DMA range ownership table: sequencer, pending list, channel state.
//
//  channel   direction  signals                                              transfer when
//  in        input      i_action i_channel i_range_address i_range_size      i_in_valid & o_in_ready
//                       i_last_range i_timed_out
//  out       output     o_result_code o_conflict_owner o_owned_now           o_out_valid & i_out_ready
//
// For a reserve item every owned-table entry is read from the table memory one per
// cycle; the scan stops at the first hit. A successful last range then writes the
// collected ranges back to the table. Reset clears channel state and the pending run.
// A result waiting in the output register stalls only an item that makes another result.
module dma_range_ownership_table_top #(
    parameter int CHANNEL_COUNT = drot_pkg::CHANNEL_COUNT_DEF,
    parameter int MAX_RANGES    = drot_pkg::MAX_RANGES_DEF,
    localparam int DEPTH  = CHANNEL_COUNT * MAX_RANGES,
    localparam int TBL_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CH_W   = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1,
    localparam int K_W    = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1,
    localparam int CNT_W  = $clog2(MAX_RANGES + 1)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_action,
    input  logic [drot_pkg::CH_FIELD_W-1:0]   i_channel,
    input  logic [drot_pkg::ADDR_W-1:0]       i_range_address,
    input  logic [drot_pkg::SIZE_W-1:0]       i_range_size,
    input  logic                              i_last_range,
    input  logic                              i_timed_out,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [drot_pkg::OUT_W-1:0]        o_result_code,
    output logic [drot_pkg::OUT_W-1:0]        o_conflict_owner,
    output logic [drot_pkg::OUT_W-1:0]        o_owned_now
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_TALLY = 5'b00100,
        S_FIN   = 5'b01000,
        S_COPY  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // held input item
    logic                            r_action;
    logic [drot_pkg::CH_FIELD_W-1:0] r_ch;
    logic [drot_pkg::ADDR_W-1:0]     r_addr;
    logic [drot_pkg::SIZE_W-1:0]     r_size;
    logic                            r_last;
    logic                            r_tmo;

    // channel state
    logic [CNT_W-1:0] r_owned_total [CHANNEL_COUNT];
    logic             r_faulted     [CHANNEL_COUNT];

    // pending reservation
    logic [drot_pkg::ADDR_W-1:0] r_pend_start [MAX_RANGES];
    logic [drot_pkg::SIZE_W-1:0] r_pend_len   [MAX_RANGES];
    logic [CNT_W-1:0]            r_pend_total, n_pend_total;
    drot_pkg::t_verdict          r_verdict, n_verdict;
    logic [CH_W-1:0]             r_owner, n_owner;

    // scan result
    logic            r_hit;
    logic [CH_W-1:0] r_hit_owner;

    // write-back
    logic [K_W-1:0]   r_copy_k;
    logic [CNT_W-1:0] r_copy_n;
    logic [TBL_W-1:0] r_base;

    // output register
    logic                         r_out_valid;
    drot_pkg::t_code              r_code, n_code;
    logic [drot_pkg::OUT_W-1:0]   r_res_owner, n_res_owner;
    logic [drot_pkg::OUT_W-1:0]   r_now, n_now;

    logic                 w_accept;
    logic                 w_out_free;
    logic                 w_out_load;
    logic                 w_ch_valid;
    logic [CH_W-1:0]      w_ch_idx;
    logic [CH_W-1:0]      w_tbl_idx;
    logic [CNT_W-1:0]     w_tbl_total;
    logic                 w_tbl_faulted;
    logic                 w_pend_wr;
    logic                 w_commit;
    logic                 w_set_total;
    logic                 w_set_fault;
    logic [CNT_W-1:0]     w_new_total;
    logic                 w_copy_end;

    drot_pkg::t_scan_req  w_req;
    drot_pkg::t_scan_stat w_stat;
    logic [CH_W-1:0]      w_scan_owner;
    logic [CH_W-1:0]      w_hit_owner;

    assign w_accept   = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || i_out_ready;

    assign w_ch_valid = 5'(r_ch) < 5'(CHANNEL_COUNT);
    assign w_ch_idx   = w_ch_valid ? r_ch[CH_W-1:0] : '0;
    // one lookup port: scan owner while scanning, else the item's channel
    assign w_tbl_idx     = (r_state == S_SCAN) ? w_scan_owner : w_ch_idx;
    assign w_tbl_total   = r_owned_total[w_tbl_idx];
    assign w_tbl_faulted = r_faulted[w_tbl_idx];

    assign w_copy_end = (CNT_W'(r_copy_k) + CNT_W'(1)) == r_copy_n;

    assign w_req.start = w_accept && (i_action == drot_pkg::ACTION_RESERVE);
    assign w_req.wr_en = (r_state == S_COPY);

    drot_scan #(
        .CHANNEL_COUNT (CHANNEL_COUNT),
        .MAX_RANGES    (MAX_RANGES)
    ) u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (w_req),
        .i_addr        (r_addr),
        .i_size        (r_size),
        .i_owner_total (w_tbl_total),
        .i_wr_addr     (r_base + TBL_W'(r_copy_k)),
        .i_wr_data     ({r_pend_start[r_copy_k], r_pend_len[r_copy_k]}),
        .o_scan_owner  (w_scan_owner),
        .o_hit_owner   (w_hit_owner),
        .o_stat        (w_stat)
    );

    always_comb begin
        n_state      = r_state;
        n_verdict    = r_verdict;
        n_owner      = r_owner;
        n_pend_total = r_pend_total;
        n_code       = drot_pkg::CODE_OK;
        n_res_owner  = '0;
        n_now        = '0;
        w_pend_wr    = 1'b0;
        w_commit     = 1'b0;
        w_out_load   = 1'b0;
        w_set_total  = 1'b0;
        w_set_fault  = 1'b0;
        w_new_total  = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_action == drot_pkg::ACTION_RESERVE) ? S_SCAN : S_FIN;
                end
            end
            S_SCAN: begin
                if (w_stat.done) begin
                    n_state = S_TALLY;
                end
            end
            S_TALLY: begin
                if (r_hit && (r_verdict == drot_pkg::VERDICT_CLEAR ||
                        (r_verdict == drot_pkg::VERDICT_CONFLICT && r_hit_owner < r_owner))) begin
                    n_verdict = drot_pkg::VERDICT_CONFLICT;
                    n_owner   = r_hit_owner;
                end
                if (r_pend_total < CNT_W'(MAX_RANGES)) begin
                    w_pend_wr    = 1'b1;
                    n_pend_total = r_pend_total + CNT_W'(1);
                end else begin
                    n_verdict = drot_pkg::VERDICT_OVERFLOW;
                end
                if (!r_last) begin
                    w_commit = 1'b1;
                    n_state  = S_IDLE;
                end else if (w_out_free) begin
                    w_commit   = 1'b1;
                    w_out_load = 1'b1;
                    n_state    = S_IDLE;
                    if (!w_ch_valid || n_verdict == drot_pkg::VERDICT_OVERFLOW) begin
                        n_code = drot_pkg::CODE_INVALID;
                        n_now  = w_ch_valid ? drot_pkg::OUT_W'(w_tbl_total) : '0;
                    end else if (w_tbl_faulted) begin
                        n_code = drot_pkg::CODE_FAULTED;
                        n_now  = drot_pkg::OUT_W'(w_tbl_total);
                    end else if (n_verdict == drot_pkg::VERDICT_CONFLICT) begin
                        n_code      = drot_pkg::CODE_CONFLICT;
                        n_res_owner = drot_pkg::OUT_W'(n_owner);
                        n_now       = drot_pkg::OUT_W'(w_tbl_total);
                    end else begin
                        n_code      = drot_pkg::CODE_OK;
                        n_now       = drot_pkg::OUT_W'(n_pend_total);
                        w_set_total = 1'b1;
                        w_new_total = n_pend_total;
                        n_state     = S_COPY;
                    end
                    // the run always ends on its last range
                    n_verdict    = drot_pkg::VERDICT_CLEAR;
                    n_owner      = '0;
                    n_pend_total = '0;
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    n_state    = S_IDLE;
                    if (!w_ch_valid) begin
                        n_code = drot_pkg::CODE_INVALID;
                    end else if (w_tbl_faulted) begin
                        n_code = drot_pkg::CODE_FAULTED;
                        n_now  = drot_pkg::OUT_W'(w_tbl_total);
                    end else if (r_tmo) begin
                        n_code      = drot_pkg::CODE_QUARANTINE;
                        n_now       = drot_pkg::OUT_W'(w_tbl_total);
                        w_set_fault = 1'b1;
                    end else begin
                        n_code      = drot_pkg::CODE_OK;
                        w_set_total = 1'b1;
                    end
                end
            end
            S_COPY: begin
                if (w_copy_end) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pend_total <= '0;
            r_verdict    <= drot_pkg::VERDICT_CLEAR;
            r_owner      <= '0;
            r_out_valid  <= 1'b0;
            for (int c = 0; c < CHANNEL_COUNT; c++) begin
                r_owned_total[c] <= '0;
                r_faulted[c]     <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            if (w_commit) begin
                r_pend_total <= n_pend_total;
                r_verdict    <= n_verdict;
                r_owner      <= n_owner;
            end
            if (w_set_total) begin
                r_owned_total[w_ch_idx] <= w_new_total;
            end
            if (w_set_fault) begin
                r_faulted[w_ch_idx] <= 1'b1;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action <= i_action;
            r_ch     <= i_channel;
            r_addr   <= i_range_address;
            r_size   <= i_range_size;
            r_last   <= i_last_range;
            r_tmo    <= i_timed_out;
        end
        if (r_state == S_SCAN && w_stat.done) begin
            r_hit       <= w_stat.hit;
            r_hit_owner <= w_hit_owner;
        end
        if (w_pend_wr && w_commit) begin
            r_pend_start[r_pend_total[K_W-1:0]] <= r_addr;
            r_pend_len[r_pend_total[K_W-1:0]]   <= r_size;
        end
        if (r_state == S_TALLY) begin
            r_copy_k <= '0;
            if (r_pend_total < CNT_W'(MAX_RANGES)) begin
                r_copy_n <= r_pend_total + CNT_W'(1);
            end else begin
                r_copy_n <= r_pend_total;
            end
            r_base <= TBL_W'(int'(w_ch_idx) * MAX_RANGES);
        end else if (r_state == S_COPY) begin
            r_copy_k <= r_copy_k + K_W'(1);
        end
        if (w_out_load) begin
            r_code      <= n_code;
            r_res_owner <= n_res_owner;
            r_now       <= n_now;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_result_code    = r_code;
    assign o_conflict_owner = r_res_owner;
    assign o_owned_now      = r_now;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_total <= CNT_W'(MAX_RANGES))
        else $error("pending run longer than the list");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_verdict == drot_pkg::VERDICT_OVERFLOW |-> r_pend_total == CNT_W'(MAX_RANGES))
        else $error("overflow verdict with room left");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |-> w_out_free)
        else $error("result overwrote an untaken transfer");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_COPY |-> (CNT_W'(r_copy_k) < r_copy_n) && !r_action)
        else $error("write-back past the collected ranges");

endmodule

// ===== tb/sv/tb_dma_range_ownership_table_top.sv =====
// Self-checking testbench for the DMA range ownership table: directed and random reservations and finishes.
`timescale 1ns / 1ps

module tb_dma_range_ownership_table_top;

    localparam int CH_N = drot_pkg::CHANNEL_COUNT_DEF;
    localparam int MAX_R = drot_pkg::MAX_RANGES_DEF;
    localparam int CH_FIELD_W = drot_pkg::CH_FIELD_W;
    localparam int ADDR_W = drot_pkg::ADDR_W;
    localparam int SIZE_W = drot_pkg::SIZE_W;
    localparam int OUT_W = drot_pkg::OUT_W;
    localparam logic ACTION_RESERVE = drot_pkg::ACTION_RESERVE;
    localparam logic ACTION_FINISH = ~drot_pkg::ACTION_RESERVE;
    // one full table scan plus the write-back of a full list, with margin
    localparam int SETTLE_CYCLES = CH_N * MAX_R + MAX_R + 40;
    localparam int HOLD_CYCLES = 800;
    localparam int FAULT_BUDGET = 5;
    localparam int ITEM_TARGET = 1300;

    typedef struct {
        logic                  action;
        logic [CH_FIELD_W-1:0] channel;
        logic [ADDR_W-1:0]     addr;
        logic [SIZE_W-1:0]     size;
        logic                  last;
        logic                  tmo;
    } t_item;

    typedef struct {
        drot_pkg::t_code  code;
        logic [OUT_W-1:0] owner;
        logic [OUT_W-1:0] now;
    } t_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic                  i_action;
    logic [CH_FIELD_W-1:0] i_channel;
    logic [ADDR_W-1:0]     i_range_address;
    logic [SIZE_W-1:0]     i_range_size;
    logic                  i_last_range;
    logic                  i_timed_out;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [OUT_W-1:0]      o_result_code;
    logic [OUT_W-1:0]      o_conflict_owner;
    logic [OUT_W-1:0]      o_owned_now;

    dma_range_ownership_table_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_action         (i_action),
        .i_channel        (i_channel),
        .i_range_address  (i_range_address),
        .i_range_size     (i_range_size),
        .i_last_range     (i_last_range),
        .i_timed_out      (i_timed_out),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_result_code    (o_result_code),
        .o_conflict_owner (o_conflict_owner),
        .o_owned_now      (o_owned_now)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predicted table state
    logic [ADDR_W-1:0]  own_start [CH_N*MAX_R];
    logic [SIZE_W-1:0]  own_len [CH_N*MAX_R];
    int unsigned        own_cnt [CH_N];
    bit                 ch_faulted [CH_N];
    logic [ADDR_W-1:0]  pend_start [MAX_R];
    logic [SIZE_W-1:0]  pend_len [MAX_R];
    int unsigned        pend_cnt;
    drot_pkg::t_verdict pend_verdict;
    int unsigned        pend_owner;

    t_item   item_q [$];
    t_result result_q [$];
    t_item   cur_item;

    bit gen_faulted [CH_N];
    int faults_made;
    int items_made;
    int errors;
    int results_seen;

    bit in_taken;
    bit out_taken;
    int in_gap;
    int out_gap;
    int in_quiet;
    int out_quiet;
    int hold_left;
    int hold_requests;
    int hold_served;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d (result #%0d)",
                 $realtime, what, got, want, results_seen);
        errors++;
    endtask

    // later start must fall inside the earlier range; differences wrap at 32 bits
    function automatic bit spans_overlap(input logic [ADDR_W-1:0] a,
                                         input logic [SIZE_W-1:0] alen,
                                         input logic [ADDR_W-1:0] b,
                                         input logic [SIZE_W-1:0] blen);
        logic [ADDR_W-1:0] diff;
        if (a < b) begin
            diff = b - a;
            return diff < {{(ADDR_W-SIZE_W){1'b0}}, alen};
        end
        diff = a - b;
        return diff < {{(ADDR_W-SIZE_W){1'b0}}, blen};
    endfunction

    task automatic ownership_step(input t_item it);
        t_result r;
        int      ch;
        bit      ok_ch;
        bit      found;
        int      hit_owner;
        int      o;
        int      k;
        int      e;
        ch = int'(it.channel);
        ok_ch = ch < CH_N;
        r.owner = '0;
        if (it.action == ACTION_FINISH) begin
            if (!ok_ch) begin
                r.code = drot_pkg::CODE_INVALID;
                r.now = '0;
            end else if (ch_faulted[ch]) begin
                r.code = drot_pkg::CODE_FAULTED;
                r.now = OUT_W'(own_cnt[ch]);
            end else if (it.tmo) begin
                ch_faulted[ch] = 1'b1;
                r.code = drot_pkg::CODE_QUARANTINE;
                r.now = OUT_W'(own_cnt[ch]);
            end else begin
                own_cnt[ch] = 0;
                r.code = drot_pkg::CODE_OK;
                r.now = '0;
            end
            result_q.push_back(r);
            return;
        end

        // lowest owner with any range overlapping this one
        found = 1'b0;
        hit_owner = 0;
        for (o = 0; o < CH_N && !found; o++) begin
            for (k = 0; k < int'(own_cnt[o]); k++) begin
                e = o * MAX_R + k;
                if (spans_overlap(it.addr, it.size, own_start[e], own_len[e])) begin
                    found = 1'b1;
                end
            end
            if (found) begin
                hit_owner = o;
            end
        end
        if (found && (pend_verdict == drot_pkg::VERDICT_CLEAR ||
                      (pend_verdict == drot_pkg::VERDICT_CONFLICT &&
                       hit_owner < int'(pend_owner)))) begin
            pend_verdict = drot_pkg::VERDICT_CONFLICT;
            pend_owner = hit_owner;
        end
        if (pend_cnt < MAX_R) begin
            pend_start[pend_cnt] = it.addr;
            pend_len[pend_cnt] = it.size;
            pend_cnt++;
        end else begin
            pend_verdict = drot_pkg::VERDICT_OVERFLOW;
        end
        if (!it.last) begin
            return;
        end

        if (!ok_ch || pend_verdict == drot_pkg::VERDICT_OVERFLOW) begin
            r.code = drot_pkg::CODE_INVALID;
            r.now = ok_ch ? OUT_W'(own_cnt[ch]) : '0;
        end else if (ch_faulted[ch]) begin
            r.code = drot_pkg::CODE_FAULTED;
            r.now = OUT_W'(own_cnt[ch]);
        end else if (pend_verdict == drot_pkg::VERDICT_CONFLICT) begin
            r.code = drot_pkg::CODE_CONFLICT;
            r.owner = OUT_W'(pend_owner);
            r.now = OUT_W'(own_cnt[ch]);
        end else begin
            for (k = 0; k < int'(pend_cnt); k++) begin
                own_start[ch*MAX_R+k] = pend_start[k];
                own_len[ch*MAX_R+k] = pend_len[k];
            end
            own_cnt[ch] = pend_cnt;
            r.code = drot_pkg::CODE_OK;
            r.now = OUT_W'(pend_cnt);
        end
        pend_cnt = 0;
        pend_verdict = drot_pkg::VERDICT_CLEAR;
        pend_owner = 0;
        result_q.push_back(r);
    endtask

    // ---------------- stimulus helpers ----------------

    task automatic queue_item(input logic action, input int ch, input logic [ADDR_W-1:0] addr,
                              input logic [SIZE_W-1:0] size, input logic last, input logic tmo);
        t_item it;
        it.action = action;
        it.channel = CH_FIELD_W'(ch);
        it.addr = addr;
        it.size = size;
        it.last = last;
        it.tmo = tmo;
        if (action == ACTION_FINISH && ch < CH_N && tmo && !gen_faulted[ch]) begin
            gen_faulted[ch] = 1'b1;
            faults_made++;
        end
        item_q.push_back(it);
        items_made++;
    endtask

    function automatic int pick_channel();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(CH_N, (1 << CH_FIELD_W) - 1);
        end
        return $urandom_range(0, CH_N - 1);
    endfunction

    // per-channel regions keep most reservations apart; a shared window forces conflicts
    function automatic logic [ADDR_W-1:0] pick_addr(input int ch);
        logic [ADDR_W-1:0] base;
        base = ADDR_W'(ch) << 28;
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return 32'hFFFF_F000 + $urandom_range(0, 32'hFFF);
            2, 3, 4: return 32'h0800_0000 + $urandom_range(0, 32'h3FFF);
            default: return base + $urandom_range(0, 32'h1FFF);
        endcase
    endfunction

    function automatic logic [SIZE_W-1:0] pick_size();
        case ($urandom_range(0, 29))
            0: return '0;
            1: return '1;
            2: return SIZE_W'($urandom);
            default: return SIZE_W'($urandom_range(1, 32'h400));
        endcase
    endfunction

    task automatic add_finish();
        int   ch;
        logic tmo;
        ch = pick_channel();
        tmo = ($urandom_range(0, 24) == 0);
        // faulted channels never recover, so keep some channels usable
        if (tmo && ch < CH_N && !gen_faulted[ch] && faults_made >= FAULT_BUDGET) begin
            tmo = 1'b0;
        end
        queue_item(ACTION_FINISH, ch, $urandom, SIZE_W'($urandom), 1'($urandom_range(0, 1)),
                   tmo);
    endtask

    task automatic add_reservation();
        int n;
        int ch;
        int i;
        int item_ch;
        ch = pick_channel();
        n = ($urandom_range(0, 11) == 0) ? $urandom_range(MAX_R + 1, MAX_R + 2)
                                         : $urandom_range(1, MAX_R);
        for (i = 0; i < n; i++) begin
            item_ch = (i == n - 1 || $urandom_range(0, 9) != 0) ? ch : $urandom_range(0, 15);
            queue_item(ACTION_RESERVE, item_ch, pick_addr(ch), pick_size(), i == n - 1,
                       1'($urandom_range(0, 1)));
            if (i != n - 1 && $urandom_range(0, 19) == 0) begin
                add_finish();
            end
        end
    endtask

    task automatic add_random_items(input int target);
        int roll;
        while (items_made < target) begin
            roll = $urandom_range(0, 99);
            if (roll < 65) begin
                add_reservation();
            end else if (roll < 90) begin
                add_finish();
            end else begin
                queue_item(ACTION_RESERVE, $urandom_range(0, 15), $urandom, SIZE_W'($urandom),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    task automatic wait_idle();
        while (item_q.size() != 0 || i_in_valid || result_q.size() != 0) begin
            @(posedge i_clk);
        end
        // a range with no result may still be scanning
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 20);
        return $urandom_range(40, 120);
    endfunction

    // ---------------- driver ----------------

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (in_taken) begin
                if (in_quiet > 0) begin
                    in_quiet--;
                    in_gap = 0;
                end else begin
                    in_gap = gap_len();
                    if ($urandom_range(0, 39) == 0) in_quiet = $urandom_range(10, 40);
                end
            end
            if (!i_in_valid || in_taken) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (item_q.size() != 0) begin
                    cur_item = item_q.pop_front();
                    i_action <= cur_item.action;
                    i_channel <= cur_item.channel;
                    i_range_address <= cur_item.addr;
                    i_range_size <= cur_item.size;
                    i_last_range <= cur_item.last;
                    i_timed_out <= cur_item.tmo;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- result receiver ----------------

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = HOLD_CYCLES - 1;
            i_out_ready <= 1'b0;
        end else begin
            if (out_taken) begin
                if (out_quiet > 0) begin
                    out_quiet--;
                    out_gap = 0;
                end else begin
                    out_gap = gap_len();
                    if ($urandom_range(0, 39) == 0) out_quiet = $urandom_range(10, 40);
                end
            end
            if (out_gap > 0) begin
                out_gap--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // ---------------- monitor and prediction ----------------

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
            out_taken <= 1'b0;
        end else begin
            in_taken <= i_in_valid && o_in_ready;
            out_taken <= o_out_valid && i_out_ready;
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (result_q.size() == 0) begin
                    report_mismatch("result with nothing expected", int'(o_result_code), -1);
                end else begin
                    want = result_q.pop_front();
                    if (o_result_code !== want.code) begin
                        report_mismatch("result_code", int'(o_result_code), int'(want.code));
                    end
                    if (o_conflict_owner !== want.owner) begin
                        report_mismatch("conflict_owner", int'(o_conflict_owner),
                                        int'(want.owner));
                    end
                    if (o_owned_now !== want.now) begin
                        report_mismatch("owned_now", int'(o_owned_now), int'(want.now));
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                ownership_step(cur_item);
            end
        end
    end

    // ---------------- sequence ----------------

    initial begin
        int i;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_action = ACTION_RESERVE;
        i_channel = '0;
        i_range_address = '0;
        i_range_size = '0;
        i_last_range = 1'b0;
        i_timed_out = 1'b0;
        i_out_ready = 1'b0;
        for (i = 0; i < CH_N; i++) begin
            own_cnt[i] = 0;
            ch_faulted[i] = 1'b0;
            gen_faulted[i] = 1'b0;
        end
        pend_cnt = 0;
        pend_verdict = drot_pkg::VERDICT_CLEAR;
        pend_owner = 0;

        // finish on an empty channel, with every range field at its top value
        queue_item(ACTION_FINISH, 0, 32'hFFFF_FFFF, 24'hFF_FFFF, 1'b1, 1'b0);
        // zero-size range at address zero; timeout flag ignored on reserve
        queue_item(ACTION_RESERVE, 0, 32'h0, 24'h0, 1'b1, 1'b1);
        // zero-size owned range never contains anything
        queue_item(ACTION_RESERVE, 1, 32'h0, 24'h1, 1'b1, 1'b0);
        queue_item(ACTION_RESERVE, 2, 32'hFFFF_FFFF, 24'hFF_FFFF, 1'b1, 1'b0);
        // ranges of one reservation may overlap each other
        queue_item(ACTION_RESERVE, 3, 32'h1000, 24'h100, 1'b0, 1'b0);
        queue_item(ACTION_RESERVE, 3, 32'h1080, 24'h100, 1'b1, 1'b0);
        // zero-size range starting inside an owned range
        queue_item(ACTION_RESERVE, 4, 32'h10FF, 24'h0, 1'b1, 1'b0);
        // two conflicts, the later one with a lower owner wins
        queue_item(ACTION_RESERVE, 5, 32'h1000, 24'h10, 1'b0, 1'b0);
        queue_item(ACTION_RESERVE, 5, 32'h0, 24'h10, 1'b1, 1'b0);
        // too many ranges
        for (i = 0; i <= MAX_R; i++) begin
            queue_item(ACTION_RESERVE, 6, 32'h2000 + i * 32'h100, 24'h10, i == MAX_R, 1'b0);
        end
        queue_item(ACTION_RESERVE, 8, 32'h5000, 24'h10, 1'b1, 1'b0);
        queue_item(ACTION_FINISH, 15, 32'h0, 24'h0, 1'b0, 1'b1);
        // quarantine, then a faulted channel refuses finishes and reservations
        queue_item(ACTION_FINISH, 3, 32'h0, 24'h0, 1'b0, 1'b1);
        queue_item(ACTION_FINISH, 3, 32'h0, 24'h0, 1'b0, 1'b0);
        queue_item(ACTION_RESERVE, 3, 32'h9000, 24'h10, 1'b1, 1'b0);
        queue_item(ACTION_RESERVE, 4, 32'h1000, 24'h10, 1'b1, 1'b0);
        // finish in the middle of another channel's reservation
        queue_item(ACTION_RESERVE, 7, 32'h3000, 24'h10, 1'b0, 1'b0);
        queue_item(ACTION_FINISH, 1, 32'h0, 24'h0, 1'b0, 1'b0);
        queue_item(ACTION_RESERVE, 7, 32'h3100, 24'h10, 1'b1, 1'b0);
        // full list replaces the old one
        for (i = 0; i < MAX_R; i++) begin
            queue_item(ACTION_RESERVE, 0, 32'h4000 + i * 32'h100, 24'h20, i == MAX_R - 1, 1'b0);
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        wait_idle();
        repeat ($urandom_range(20, 200)) @(posedge i_clk);

        // receiver stalls for a long stretch while the sender keeps offering
        hold_requests++;
        add_random_items(ITEM_TARGET / 2);
        wait_idle();
        // sender pauses with nothing outstanding
        repeat ($urandom_range(20, 200)) @(posedge i_clk);
        add_random_items(ITEM_TARGET);
        wait_idle();

        if (result_q.size() != 0) begin
            report_mismatch("results never delivered", result_q.size(), 0);
        end
        if (errors == 0) begin
            $display("** dma_range_ownership_table_top: PASSED **");
        end else begin
            $display("** dma_range_ownership_table_top: FAILED **");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("** dma_range_ownership_table_top: FAILED **");
        $finish;
    end

endmodule
